// ----- hw/rtl/i2cseq_pkg.sv -----
package i2cseq_pkg;

   localparam int RING_DEPTH = 8;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(RING_DEPTH + 1);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ACK_LEVEL       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_ACK_LEVEL = 1'd1;

   typedef logic [1:0] kind_type;
   typedef logic [3:0] status_type;
   typedef logic [4:0] cmd_type;

   localparam kind_type KIND_REQUEST   = 2'd0;
   localparam kind_type KIND_BYTE_DONE = 2'd1;
   localparam kind_type KIND_POP       = 2'd2;

   localparam status_type ST_STEP_ISSUED  = 4'd0;
   localparam status_type ST_BUSY_REJECT  = 4'd1;
   localparam status_type ST_READ_START   = 4'd2;
   localparam status_type ST_WRITE_START  = 4'd3;
   localparam status_type ST_READ_DONE    = 4'd4;
   localparam status_type ST_WRITE_DONE   = 4'd5;
   localparam status_type ST_POP_EMPTY    = 4'd6;
   localparam status_type ST_POP_ENTRY    = 4'd7;
   localparam status_type ST_IDLE_IGNORED = 4'd8;

   localparam cmd_type CMD_START = 5'b00001;
   localparam cmd_type CMD_STOP  = 5'b00010;
   localparam cmd_type CMD_READ  = 5'b00100;
   localparam cmd_type CMD_WRITE = 5'b01000;
   localparam cmd_type CMD_NACK  = 5'b10000;

   localparam logic [2:0] STEP_IDLE = 3'd0;
   localparam logic [2:0] STEP_MAX  = 3'd5;

   typedef struct packed {
      logic [6:0]  address;
      logic [7:0]  pointer;
      logic [15:0] data;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic        cmd_valid;
      logic        cmd_start;
      logic        cmd_stop;
      logic        cmd_read;
      logic        cmd_write;
      logic        cmd_nack;
      logic [7:0]  tx_byte;
      logic [6:0]  entry_address;
      logic [7:0]  entry_pointer;
      logic [15:0] entry_data;
      logic [15:0] overflow_count;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/i2cseq_req_if.sv -----
interface i2cseq_req_if;
   logic                  valid;
   logic                  ready;
   i2cseq_pkg::kind_type  kind;
   logic [6:0]            dev_address;
   logic [7:0]            reg_pointer;
   logic [15:0]           data_word;
   logic                  ptr_set;
   logic                  is_write;
   logic                  word_mode;
   logic [7:0]            rx_byte;

   modport source (
      output valid, kind, dev_address, reg_pointer, data_word, ptr_set, is_write,
             word_mode, rx_byte,
      input  ready
   );

   modport sink (
      input  valid, kind, dev_address, reg_pointer, data_word, ptr_set, is_write,
             word_mode, rx_byte,
      output ready
   );
endinterface

// ----- hw/rtl/i2cseq_rsp_if.sv -----
interface i2cseq_rsp_if;
   logic                   valid;
   logic                   ready;
   i2cseq_pkg::status_type status;
   logic                   cmd_valid;
   logic                   cmd_start;
   logic                   cmd_stop;
   logic                   cmd_read;
   logic                   cmd_write;
   logic                   cmd_nack;
   logic [7:0]             tx_byte;
   logic [6:0]             entry_address;
   logic [7:0]             entry_pointer;
   logic [15:0]            entry_data;
   logic [15:0]            overflow_count;

   modport source (
      output valid, status, cmd_valid, cmd_start, cmd_stop, cmd_read, cmd_write, cmd_nack,
             tx_byte, entry_address, entry_pointer, entry_data, overflow_count,
      input  ready
   );

   modport sink (
      input  valid, status, cmd_valid, cmd_start, cmd_stop, cmd_read, cmd_write, cmd_nack,
             tx_byte, entry_address, entry_pointer, entry_data, overflow_count,
      output ready
   );
endinterface

// ----- hw/rtl/i2c_register_transaction_sequencer.sv -----
// I2C register transaction sequencer: turns register read and write transactions into
// byte-controller commands and keeps finished reads in a ring buffer.
// req_ch carries three kinds of request: a transaction (device address, pointer, data
// and mode bits), a byte-done event from the byte controller (with the received byte)
// and a pop of the oldest stored read result. Every request yields exactly one response
// on rsp_ch: the command to issue, a start/done/reject status or the popped entry,
// always together with the saturating ring overflow count.
// csr_wr_en/csr_index/csr_wdata write the ack level for non-final steps (index 0) and
// for the final step (index 1); write them only while the block is idle.
// Throughput: one request per clock while the receiver keeps rsp_ch.ready high. Each
// response is registered in the read stage, which holds the registered read port of the
// result ring, and then in the output register that drives rsp_ch.valid.
// Reset clears the sequencer to idle, empties the ring, zeroes the overflow count and
// both ack levels; ring contents are left as they are.
// When rsp_ch.ready is low, one response waits in the output register and one more
// request is still taken into the read stage; after that req_ch.ready drops until the
// receiver takes a response.
module i2c_register_transaction_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   i2cseq_req_if.sink                          req_ch,
   i2cseq_rsp_if.source                        rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [i2cseq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [i2cseq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import i2cseq_pkg::*;

   typedef struct packed {
      logic [6:0]  address;
      logic [7:0]  pointer;
      logic [15:0] data;
      logic        ptr_set;
      logic        wr;
      logic        word;
      logic        ack;
      logic        fack;
   } txn_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx;
   } step_type;

   function automatic logic [2:0] header_len(input txn_type t);
      logic [2:0] n;
      if (t.ptr_set || t.wr) begin
         n = t.wr ? 3'd2 : 3'd3;
      end else begin
         n = 3'd1;
      end
      return n;
   endfunction

   function automatic step_type step_at(input logic [2:0] idx, input txn_type t);
      step_type   s;
      cmd_type    ackc;
      cmd_type    fackc;
      cmd_type    dir;
      logic [2:0] hdr;
      ackc  = t.ack ? CMD_NACK : '0;
      fackc = t.fack ? CMD_NACK : '0;
      dir   = t.wr ? CMD_WRITE : CMD_READ;
      hdr   = header_len(t);
      if (idx < hdr) begin
         if (!(t.ptr_set || t.wr) || idx == 3'd2) begin
            s = '{cmd: CMD_START | CMD_WRITE | ackc, tx: {t.address, 1'b1}};
         end else if (idx == 3'd0) begin
            s = '{cmd: CMD_START | CMD_WRITE | ackc, tx: {t.address, 1'b0}};
         end else begin
            s = '{cmd: CMD_WRITE | ackc, tx: t.pointer};
         end
      end else if (t.word && idx == hdr) begin
         s = '{cmd: dir | ackc, tx: t.data[15:8]};
      end else begin
         s = '{cmd: dir | CMD_STOP | fackc, tx: t.data[7:0]};
      end
      return s;
   endfunction

   function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] x);
      return (x == RING_AW'(RING_DEPTH - 1)) ? '0 : x + 1'b1;
   endfunction

   // control state
   logic [2:0]         step_index_ff, step_index_in;
   logic [RING_AW-1:0] write_slot_ff, write_slot_in;
   logic [RING_AW-1:0] read_slot_ff, read_slot_in;
   logic [COUNT_W-1:0] stored_count_ff, stored_count_in;
   logic [15:0]        overflow_ff, overflow_in;
   logic               ack_level_ff, ack_level_in;
   logic               final_ack_ff, final_ack_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               out_valid_ff, out_valid_in;

   // payload state
   txn_type            txn_ff, txn_in;
   entry_type          entry_ff, entry_in;
   rsp_payload_type    s1_rsp_ff, s1_rsp_in;
   logic               s1_pop_ff, s1_pop_in;
   rsp_payload_type    out_rsp_ff, out_rsp_in;
   entry_type          rd_data_ff;

   // result ring
   entry_type          ring_mem [RING_DEPTH];
   logic               mem_we;
   logic               mem_re;

   logic               req_acc;
   logic               out_load;
   logic [2:0]         last_step;
   txn_type            new_txn;
   step_type           first_step;
   step_type           cur_step;
   step_type           prev_step;

   assign out_load     = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || out_load;
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign new_txn = '{address: req_ch.dev_address, pointer: req_ch.reg_pointer,
                      data: req_ch.data_word, ptr_set: req_ch.ptr_set,
                      wr: req_ch.is_write, word: req_ch.word_mode,
                      ack: ack_level_ff, fack: final_ack_ff};

   assign last_step  = header_len(txn_ff) + {2'b00, txn_ff.word};
   assign first_step = step_at(3'd0, new_txn);
   assign cur_step   = step_at(step_index_ff, txn_ff);
   assign prev_step  = step_at(step_index_ff - 3'd1, txn_ff);

   always_comb begin
      ack_level_in = ack_level_ff;
      final_ack_in = final_ack_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACK_LEVEL:       ack_level_in = csr_wdata[0];
            CSR_FINAL_ACK_LEVEL: final_ack_in = csr_wdata[0];
            default:             ;
         endcase
      end
   end

   always_comb begin
      step_index_in   = step_index_ff;
      write_slot_in   = write_slot_ff;
      read_slot_in    = read_slot_ff;
      stored_count_in = stored_count_ff;
      overflow_in     = overflow_ff;
      txn_in          = txn_ff;
      entry_in        = entry_ff;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      s1_rsp_in       = '0;
      s1_pop_in       = 1'b0;

      if (req_acc) begin
         unique case (req_ch.kind)
            KIND_REQUEST: begin
               if (step_index_ff != STEP_IDLE) begin
                  s1_rsp_in.status = ST_BUSY_REJECT;
               end else begin
                  txn_in        = new_txn;
                  step_index_in = 3'd1;
                  s1_rsp_in.status    = new_txn.wr ? ST_WRITE_START : ST_READ_START;
                  s1_rsp_in.cmd_valid = 1'b1;
                  s1_rsp_in.cmd_start = first_step.cmd[0];
                  s1_rsp_in.cmd_stop  = first_step.cmd[1];
                  s1_rsp_in.cmd_read  = first_step.cmd[2];
                  s1_rsp_in.cmd_write = first_step.cmd[3];
                  s1_rsp_in.cmd_nack  = first_step.cmd[4];
                  s1_rsp_in.tx_byte   = first_step.tx;
                  if (!new_txn.wr) begin
                     // stage address and pointer in the slot at write_slot
                     entry_in = '{address: new_txn.address, pointer: new_txn.pointer,
                                  data: 16'h0000};
                     mem_we   = 1'b1;
                  end
               end
            end
            KIND_BYTE_DONE: begin
               if (step_index_ff == STEP_IDLE || step_index_ff > STEP_MAX) begin
                  s1_rsp_in.status = ST_IDLE_IGNORED;
               end else if (step_index_ff <= last_step) begin
                  if ((prev_step.cmd & CMD_READ) != '0 && (prev_step.cmd & CMD_STOP) == '0) begin
                     entry_in.data = {req_ch.rx_byte, 8'h00};
                     mem_we        = 1'b1;
                  end
                  step_index_in       = step_index_ff + 3'd1;
                  s1_rsp_in.status    = ST_STEP_ISSUED;
                  s1_rsp_in.cmd_valid = 1'b1;
                  s1_rsp_in.cmd_start = cur_step.cmd[0];
                  s1_rsp_in.cmd_stop  = cur_step.cmd[1];
                  s1_rsp_in.cmd_read  = cur_step.cmd[2];
                  s1_rsp_in.cmd_write = cur_step.cmd[3];
                  s1_rsp_in.cmd_nack  = cur_step.cmd[4];
                  s1_rsp_in.tx_byte   = cur_step.tx;
               end else begin
                  if ((prev_step.cmd & CMD_READ) != '0 && (prev_step.cmd & CMD_STOP) != '0) begin
                     entry_in.data = entry_ff.data | {8'h00, req_ch.rx_byte};
                  end
                  step_index_in = STEP_IDLE;
                  if (txn_ff.wr) begin
                     s1_rsp_in.status = ST_WRITE_DONE;
                  end else begin
                     mem_we        = 1'b1;
                     write_slot_in = ring_inc(write_slot_ff);
                     if (write_slot_in == ring_inc(read_slot_ff)) begin
                        stored_count_in = COUNT_W'(1);
                        if (overflow_ff != 16'hFFFF) begin
                           overflow_in = overflow_ff + 16'd1;
                        end
                     end else if (stored_count_ff < COUNT_W'(RING_DEPTH)) begin
                        stored_count_in = stored_count_ff + 1'b1;
                     end
                     s1_rsp_in.status        = ST_READ_DONE;
                     s1_rsp_in.entry_address = entry_in.address;
                     s1_rsp_in.entry_pointer = entry_in.pointer;
                     s1_rsp_in.entry_data    = entry_in.data;
                  end
               end
            end
            KIND_POP: begin
               if (stored_count_ff == '0) begin
                  s1_rsp_in.status = ST_POP_EMPTY;
               end else begin
                  stored_count_in  = stored_count_ff - 1'b1;
                  read_slot_in     = ring_inc(read_slot_ff);
                  mem_re           = 1'b1;
                  s1_pop_in        = 1'b1;
                  s1_rsp_in.status = ST_POP_ENTRY;
               end
            end
            default: begin
               s1_rsp_in.status = ST_IDLE_IGNORED;
            end
         endcase
      end
      s1_rsp_in.overflow_count = overflow_in;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      out_rsp_in = s1_rsp_ff;
      if (s1_pop_ff) begin
         out_rsp_in.entry_address = rd_data_ff.address;
         out_rsp_in.entry_pointer = rd_data_ff.pointer;
         out_rsp_in.entry_data    = rd_data_ff.data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[write_slot_ff] <= entry_in;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[read_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_index_ff   <= STEP_IDLE;
         write_slot_ff   <= '0;
         read_slot_ff    <= '0;
         stored_count_ff <= '0;
         overflow_ff     <= '0;
         ack_level_ff    <= 1'b0;
         final_ack_ff    <= 1'b0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         step_index_ff   <= step_index_in;
         write_slot_ff   <= write_slot_in;
         read_slot_ff    <= read_slot_in;
         stored_count_ff <= stored_count_in;
         overflow_ff     <= overflow_in;
         ack_level_ff    <= ack_level_in;
         final_ack_ff    <= final_ack_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      txn_ff   <= txn_in;
      entry_ff <= entry_in;
      if (req_acc) begin
         s1_rsp_ff <= s1_rsp_in;
         s1_pop_ff <= s1_pop_in;
      end
      if (out_load) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_rsp_ff.status;
   assign rsp_ch.cmd_valid      = out_rsp_ff.cmd_valid;
   assign rsp_ch.cmd_start      = out_rsp_ff.cmd_start;
   assign rsp_ch.cmd_stop       = out_rsp_ff.cmd_stop;
   assign rsp_ch.cmd_read       = out_rsp_ff.cmd_read;
   assign rsp_ch.cmd_write      = out_rsp_ff.cmd_write;
   assign rsp_ch.cmd_nack       = out_rsp_ff.cmd_nack;
   assign rsp_ch.tx_byte        = out_rsp_ff.tx_byte;
   assign rsp_ch.entry_address  = out_rsp_ff.entry_address;
   assign rsp_ch.entry_pointer  = out_rsp_ff.entry_pointer;
   assign rsp_ch.entry_data     = out_rsp_ff.entry_data;
   assign rsp_ch.overflow_count = out_rsp_ff.overflow_count;

   // sequencer never runs past the last possible step
   assert property (@(posedge clock) disable iff (reset)
      step_index_ff <= STEP_MAX)
      else $error("step index beyond last step");

   assert property (@(posedge clock) disable iff (reset)
      stored_count_ff <= COUNT_W'(RING_DEPTH))
      else $error("ring fill count above depth");

   // at most one ring access per request
   assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("ring written and read in one cycle");

   assert property (@(posedge clock) disable iff (reset)
      req_acc && req_ch.kind == KIND_POP && stored_count_ff == '0
      |=> s1_rsp_ff.status == ST_POP_EMPTY && !s1_pop_ff)
      else $error("pop of an empty ring returned an entry");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> overflow_ff >= $past(overflow_ff))
      else $error("overflow count decreased");

endmodule

// ----- tb/tb_i2c_register_transaction_sequencer.sv -----
`timescale 1ns / 1ps

module tb_i2c_register_transaction_sequencer;
   import i2cseq_pkg::*;

   localparam kind_type KIND_UNUSED    = 2'd3;
   localparam int       WATCHDOG_LIMIT = 2000;
   localparam int       LONG_HOLD      = 100;

   typedef struct {
      kind_type    kind;
      logic [6:0]  dev_address;
      logic [7:0]  reg_pointer;
      logic [15:0] data_word;
      logic        ptr_set;
      logic        is_write;
      logic        word_mode;
      logic [7:0]  rx_byte;
   } sequencer_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   i2cseq_req_if req_ch ();
   i2cseq_rsp_if rsp_ch ();

   i2c_register_transaction_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sequencer shadow state
   bit         ack_cfg;
   bit         final_ack_cfg;
   int         issued_steps;
   int         final_step;
   cmd_type    step_cmd_model [5];
   logic [7:0] step_byte_model [5];
   bit         write_pending;
   entry_type  ring_model [RING_DEPTH];
   int         commit_slot;
   int         pop_slot;
   int         ring_fill;
   logic [15:0] overflow_model;

   sequencer_request_type pending_requests [$];
   rsp_payload_type       expected_responses [$];

   int  queued;
   int  accepted;
   int  responses;
   int  errors;
   int  idle_cycles;
   int  status_tally [16];
   bit  req_taken;

   int  burst_left;
   int  gap_left;
   logic [7:0] stall_mask = 8'hFF;
   int  stall_age;
   int  hold_left;
   bit  hold_done;
   bit  long_hold_armed;

   function automatic rsp_payload_type with_command(rsp_payload_type o, int idx);
      cmd_type c = step_cmd_model[idx];
      o.cmd_valid = 1'b1;
      o.cmd_start = |(c & CMD_START);
      o.cmd_stop  = |(c & CMD_STOP);
      o.cmd_read  = |(c & CMD_READ);
      o.cmd_write = |(c & CMD_WRITE);
      o.cmd_nack  = |(c & CMD_NACK);
      o.tx_byte   = step_byte_model[idx];
      return o;
   endfunction

   function automatic rsp_payload_type predict_response(sequencer_request_type r);
      rsp_payload_type o;
      cmd_type mid_nack;
      cmd_type fin_nack;
      cmd_type data_cmd;
      cmd_type prev;
      entry_type done;
      int n;
      o = '0;
      mid_nack = ack_cfg ? CMD_NACK : '0;
      fin_nack = final_ack_cfg ? CMD_NACK : '0;
      data_cmd = r.is_write ? CMD_WRITE : CMD_READ;
      case (r.kind)
         KIND_REQUEST: begin
            if (issued_steps != 0) begin
               o.status = ST_BUSY_REJECT;
            end else begin
               n = 0;
               if (r.ptr_set || r.is_write) begin
                  step_byte_model[n] = {r.dev_address, 1'b0};
                  step_cmd_model[n]  = CMD_START | CMD_WRITE | mid_nack;
                  n++;
                  step_byte_model[n] = r.reg_pointer;
                  step_cmd_model[n]  = CMD_WRITE | mid_nack;
                  n++;
                  if (!r.is_write) begin
                     step_byte_model[n] = {r.dev_address, 1'b1};
                     step_cmd_model[n]  = CMD_START | CMD_WRITE | mid_nack;
                     n++;
                  end
               end else begin
                  step_byte_model[n] = {r.dev_address, 1'b1};
                  step_cmd_model[n]  = CMD_START | CMD_WRITE | mid_nack;
                  n++;
               end
               if (r.word_mode) begin
                  step_byte_model[n] = r.data_word[15:8];
                  step_cmd_model[n]  = data_cmd | mid_nack;
                  n++;
               end
               step_byte_model[n] = r.data_word[7:0];
               step_cmd_model[n]  = data_cmd | CMD_STOP | fin_nack;
               final_step = n;
               // read entry is staged in the ring slot straight away
               if (!r.is_write)
                  ring_model[commit_slot] = {r.dev_address, r.reg_pointer, 16'h0000};
               write_pending = r.is_write;
               o.status = r.is_write ? ST_WRITE_START : ST_READ_START;
               o = with_command(o, 0);
               issued_steps = 1;
            end
         end
         KIND_BYTE_DONE: begin
            if (issued_steps == 0) begin
               o.status = ST_IDLE_IGNORED;
            end else begin
               prev = step_cmd_model[issued_steps - 1];
               if (issued_steps <= final_step) begin
                  if ((prev & CMD_READ) != '0 && (prev & CMD_STOP) == '0)
                     ring_model[commit_slot].data = {r.rx_byte, 8'h00};
                  o.status = ST_STEP_ISSUED;
                  o = with_command(o, issued_steps);
                  issued_steps++;
               end else begin
                  if ((prev & CMD_READ) != '0 && (prev & CMD_STOP) != '0)
                     ring_model[commit_slot].data[7:0] =
                        ring_model[commit_slot].data[7:0] | r.rx_byte;
                  issued_steps = 0;
                  if (write_pending) begin
                     o.status = ST_WRITE_DONE;
                  end else begin
                     done = ring_model[commit_slot];
                     commit_slot = (commit_slot + 1) % RING_DEPTH;
                     if (commit_slot == (pop_slot + 1) % RING_DEPTH) begin
                        ring_fill = 1;
                        if (overflow_model != 16'hFFFF) overflow_model++;
                     end else if (ring_fill < RING_DEPTH) begin
                        ring_fill++;
                     end
                     o.status = ST_READ_DONE;
                     {o.entry_address, o.entry_pointer, o.entry_data} = done;
                  end
               end
            end
         end
         KIND_POP: begin
            if (ring_fill == 0) begin
               o.status = ST_POP_EMPTY;
            end else begin
               ring_fill--;
               o.status = ST_POP_ENTRY;
               {o.entry_address, o.entry_pointer, o.entry_data} = ring_model[pop_slot];
               pop_slot = (pop_slot + 1) % RING_DEPTH;
            end
         end
         default: o.status = ST_IDLE_IGNORED;
      endcase
      o.overflow_count = overflow_model;
      return o;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic sequencer_request_type random_request(kind_type k);
      sequencer_request_type r;
      r.kind        = k;
      r.dev_address = 7'($urandom_range(0, 127));
      r.reg_pointer = 8'($urandom_range(0, 255));
      r.data_word   = 16'($urandom_range(0, 65535));
      r.ptr_set     = 1'($urandom_range(0, 1));
      r.is_write    = 1'($urandom_range(0, 1));
      r.word_mode   = 1'($urandom_range(0, 1));
      r.rx_byte     = 8'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic enqueue(sequencer_request_type r);
      pending_requests.push_back(r);
      queued++;
   endtask

   // a request followed by its byte-done events, with the last few optionally cut off
   task automatic queue_transaction(logic [6:0] addr, logic [7:0] ptr, logic [15:0] data,
                                    bit pset, bit wr, bit word, int rx_fixed, int cut);
      sequencer_request_type r;
      int steps;
      r = random_request(KIND_REQUEST);
      r.dev_address = addr;
      r.reg_pointer = ptr;
      r.data_word   = data;
      r.ptr_set     = pset;
      r.is_write    = wr;
      r.word_mode   = word;
      enqueue(r);
      steps = ((pset || wr) ? (wr ? 2 : 3) : 1) + word + 1;
      for (int i = 0; i < steps - cut; i++) begin
         if ($urandom_range(0, 9) == 0)
            enqueue(random_request($urandom_range(0, 1) ? KIND_POP : KIND_REQUEST));
         r = random_request(KIND_BYTE_DONE);
         if (rx_fixed >= 0) r.rx_byte = 8'(rx_fixed);
         enqueue(r);
      end
   endtask

   task automatic queue_random_traffic(int n_items, int pop_pct);
      int first;
      int pick;
      first = queued;
      while (queued - first < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            enqueue(random_request(kind_type'($urandom_range(KIND_REQUEST, KIND_UNUSED))));
         else if (pick < 6 + pop_pct)
            enqueue(random_request(KIND_POP));
         else
            queue_transaction(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), -1,
                              ($urandom_range(0, 19) == 0) ? int'($urandom_range(1, 3)) : 0);
      end
   endtask

   task automatic drain();
      while (accepted != queued || expected_responses.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_ack_levels(bit mid, bit fin);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ACK_LEVEL;
      csr_wdata <= mid;
      @(negedge clock);
      csr_index <= CSR_FINAL_ACK_LEVEL;
      csr_wdata <= fin;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      ack_cfg       = mid;
      final_ack_cfg = fin;
   endtask

   // request driver
   always @(negedge clock) begin : request_driver
      sequencer_request_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_ch.kind        <= r.kind;
            req_ch.dev_address <= r.dev_address;
            req_ch.reg_pointer <= r.reg_pointer;
            req_ch.data_word   <= r.data_word;
            req_ch.ptr_set     <= r.ptr_set;
            req_ch.is_write    <= r.is_write;
            req_ch.word_mode   <= r.word_mode;
            req_ch.rx_byte     <= r.rx_byte;
            req_ch.valid       <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 20);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (long_hold_armed && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= stall_mask[0];
         stall_mask = {stall_mask[0], stall_mask[7:1]};
         stall_age++;
         if (stall_age == 64) begin
            stall_age  = 0;
            stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin : monitor
      rsp_payload_type       want;
      sequencer_request_type got;
      bit rsp_taken;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken = 1'b1;
            if (expected_responses.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual status %0h",
                        $time, rsp_ch.status);
               errors++;
            end else begin
               want = expected_responses.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_ch.status));
               check_field("cmd_valid", 16'(want.cmd_valid), 16'(rsp_ch.cmd_valid));
               check_field("cmd_start", 16'(want.cmd_start), 16'(rsp_ch.cmd_start));
               check_field("cmd_stop", 16'(want.cmd_stop), 16'(rsp_ch.cmd_stop));
               check_field("cmd_read", 16'(want.cmd_read), 16'(rsp_ch.cmd_read));
               check_field("cmd_write", 16'(want.cmd_write), 16'(rsp_ch.cmd_write));
               check_field("cmd_nack", 16'(want.cmd_nack), 16'(rsp_ch.cmd_nack));
               check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_ch.tx_byte));
               check_field("entry_address", 16'(want.entry_address),
                           16'(rsp_ch.entry_address));
               check_field("entry_pointer", 16'(want.entry_pointer),
                           16'(rsp_ch.entry_pointer));
               check_field("entry_data", want.entry_data, rsp_ch.entry_data);
               check_field("overflow_count", want.overflow_count, rsp_ch.overflow_count);
            end
            responses++;
         end
         if (req_ch.valid && req_ch.ready) begin
            got.kind        = req_ch.kind;
            got.dev_address = req_ch.dev_address;
            got.reg_pointer = req_ch.reg_pointer;
            got.data_word   = req_ch.data_word;
            got.ptr_set     = req_ch.ptr_set;
            got.is_write    = req_ch.is_write;
            got.word_mode   = req_ch.word_mode;
            got.rx_byte     = req_ch.rx_byte;
            want = predict_response(got);
            expected_responses.push_back(want);
            status_tally[want.status]++;
            accepted++;
            req_taken = 1'b1;
         end
      end
      idle_cycles = (req_taken || rsp_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d cycles without a handshake", $time, idle_cycles);
         $display("tb_i2c_register_transaction_sequencer failed");
         $finish;
      end
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_REQUEST;
      req_ch.dev_address = '0;
      req_ch.reg_pointer = '0;
      req_ch.data_word   = '0;
      req_ch.ptr_set     = 1'b0;
      req_ch.is_write    = 1'b0;
      req_ch.word_mode   = 1'b0;
      req_ch.rx_byte     = '0;
      rsp_ch.ready       = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_ACK_LEVEL;
      csr_wdata          = '0;
      foreach (ring_model[i]) ring_model[i] = '0;
      foreach (step_cmd_model[i]) step_cmd_model[i] = '0;
      foreach (step_byte_model[i]) step_byte_model[i] = '0;
      overflow_model = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle corner cases, then several transaction shapes at the field extremes
      enqueue(random_request(KIND_POP));
      enqueue(random_request(KIND_BYTE_DONE));
      enqueue(random_request(KIND_UNUSED));
      queue_transaction(7'h7F, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 8'hFF, 1);
      enqueue(random_request(KIND_REQUEST));
      enqueue(random_request(KIND_BYTE_DONE));
      queue_transaction(7'h00, 8'h00, 16'hFF00, 1'b0, 1'b1, 1'b1, 8'h00, 0);
      queue_transaction(7'h55, 8'hAA, 16'h0000, 1'b1, 1'b0, 1'b1, 8'h00, 0);
      queue_transaction(7'h01, 8'h80, 16'h00FF, 1'b0, 1'b0, 1'b1, 8'h5A, 0);
      enqueue(random_request(KIND_POP));
      enqueue(random_request(KIND_POP));
      drain();

      set_ack_levels(1'b1, 1'b1);
      queue_random_traffic(90, 30);
      drain();

      // few pops so the ring wraps, plus the long receiver hold-off
      set_ack_levels(1'b0, 1'b1);
      queue_random_traffic(90, 5);
      long_hold_armed = 1'b1;
      drain();

      set_ack_levels(1'b1, 1'b0);
      queue_random_traffic(90, 45);
      drain();

      set_ack_levels(1'b0, 1'b0);
      queue_random_traffic(90, 20);
      drain();

      set_ack_levels(1'b1, 1'b1);
      queue_random_traffic(90, 15);
      drain();

      $display("run covered %0d requests and %0d responses: %0d reads and %0d writes completed",
               accepted, responses, status_tally[ST_READ_DONE], status_tally[ST_WRITE_DONE]);
      $display("%0d entries popped, %0d empty pops, %0d busy rejects, overflow count %0d",
               status_tally[ST_POP_ENTRY], status_tally[ST_POP_EMPTY],
               status_tally[ST_BUSY_REJECT], overflow_model);
      if (errors == 0) begin
         $display("tb_i2c_register_transaction_sequencer passed");
      end else begin
         $display("tb_i2c_register_transaction_sequencer failed");
      end
      $finish;
   end

endmodule
